// ===== src/aabb_frustum_cull_test_unit_defines.svh =====
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_unit_defines
// assertion macros shared by the box culling unit
// ----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CULL_TEST_UNIT_DEFINES_SVH
`define AABB_FRUSTUM_CULL_TEST_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define AFCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define AFCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/afct_pkg.sv =====
// ----------------------------------------------------------------------------
// afct_pkg
// types, codes and helpers for the box versus frustum culling unit
// ----------------------------------------------------------------------------
package afct_pkg;

    localparam int COORD_BITS = 32;
    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int SUM_BITS   = 2 * COORD_BITS + 2;
    localparam int D_SHIFT    = 16;
    localparam int NUM_PLANES  = 6;
    localparam int NUM_CORNERS = 8;

    // request types
    localparam logic [1:0] REQ_PLANE  = 2'd0;
    localparam logic [1:0] REQ_CORNER = 2'd1;
    localparam logic [1:0] REQ_TEST   = 2'd2;

    // cull causes
    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_PLANE = 2'd1;
    localparam logic [1:0] CAUSE_FACE  = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec3_t;

    typedef struct packed {
        vec3_t  n;
        coord_t d;
    } plane_t;

    typedef struct packed {
        vec3_t lo;
        vec3_t hi;
    } box_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [2:0]         slot;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic signed [31:0] plane_offset;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
    } req_t;

    typedef struct packed {
        logic       visible;
        logic [1:0] cull_cause;
    } rsp_t;

    // low COORD_BITS of a port field, taken as signed
    function automatic coord_t to_coord(logic [31:0] v);
        return coord_t'(v[COORD_BITS-1:0]);
    endfunction

    // box coordinate that maximizes coef * v over {lo, hi}
    function automatic coord_t pick_extreme(coord_t coef, coord_t lo, coord_t hi);
        logic lo_smaller;
        lo_smaller = ($signed(lo) < $signed(hi));
        if (coef[COORD_BITS-1])
            return lo_smaller ? lo : hi;
        else
            return lo_smaller ? hi : lo;
    endfunction

endpackage

// ===== src/aabb_frustum_cull_test_unit.sv =====
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_unit
// conservative axis-aligned box versus view frustum culling, Q16.16
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid / req_ready / req) carries three kinds of request:
//   plane loads (slot 0..5, normal in coord_x/y/z, constant in plane_offset),
//   frustum corner loads (slot 0..7) and box tests (min in coord_x/y/z, max
//   in box_max_x/y/z). only box tests produce a response on the rsp channel
//   (rsp_valid / rsp_ready / rsp) with visible and cull_cause.
//   loads take effect at the edge they are accepted, so a test accepted on
//   the very next cycle already sees them.
// timing:
//   three-stage pipeline: input register, product register (three 32x32
//   multipliers per plane, six planes), response register. a test's response
//   shows once the test has passed through all three registers in that order.
//   one request is taken every cycle while rsp is not stalled.
// reset:
//   rst_n clears all planes and corners to zero and empties the pipeline.
// backpressure:
//   while a response waits and rsp_ready is low, the whole pipeline holds
//   and req_ready is low; requests in flight are kept, none dropped.
// ----------------------------------------------------------------------------
`include "aabb_frustum_cull_test_unit_defines.svh"

module aabb_frustum_cull_test_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  afct_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output afct_pkg::rsp_t  rsp
);

    // stored frustum description
    afct_pkg::plane_t plane_reg  [afct_pkg::NUM_PLANES];
    afct_pkg::vec3_t  corner_reg [afct_pkg::NUM_CORNERS];

    // pipeline
    logic            pipe_en;
    logic            req_accept;
    logic            s1_valid_reg;
    logic            s1_valid_next;
    afct_pkg::box_t  s1_box_reg;
    afct_pkg::box_t  s1_box_next;
    logic            s2_valid_reg;
    logic            s2_face_reg;
    logic            rsp_valid_reg;
    afct_pkg::rsp_t  rsp_reg;
    afct_pkg::rsp_t  rsp_next;

    logic                            face_beyond;
    logic [afct_pkg::NUM_PLANES-1:0] plane_outside;

    // everything advances unless a finished response is stuck at the output
    assign pipe_en    = !rsp_valid_reg || rsp_ready;
    assign req_ready  = pipe_en;
    assign req_accept = req_valid && req_ready;

    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // load requests write state directly at accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < afct_pkg::NUM_PLANES; p++)
                plane_reg[p] <= '0;
            for (int c = 0; c < afct_pkg::NUM_CORNERS; c++)
                corner_reg[c] <= '0;
        end
        else if (req_accept)
        begin
            // plane slots 6 and 7 do not exist, ignore them
            if (req.req_type == afct_pkg::REQ_PLANE &&
                32'(req.slot) < afct_pkg::NUM_PLANES)
            begin
                plane_reg[req.slot] <= '{
                    n: '{
                        x: afct_pkg::to_coord(req.coord_x),
                        y: afct_pkg::to_coord(req.coord_y),
                        z: afct_pkg::to_coord(req.coord_z)
                    },
                    d: afct_pkg::to_coord(req.plane_offset)
                };
            end
            if (req.req_type == afct_pkg::REQ_CORNER)
            begin
                corner_reg[req.slot] <= '{
                    x: afct_pkg::to_coord(req.coord_x),
                    y: afct_pkg::to_coord(req.coord_y),
                    z: afct_pkg::to_coord(req.coord_z)
                };
            end
        end
    end

    // stage 1 capture: only test requests become pipeline entries
    always_comb
    begin
        s1_valid_next = req_accept && (req.req_type == afct_pkg::REQ_TEST);
        s1_box_next.lo.x = afct_pkg::to_coord(req.coord_x);
        s1_box_next.lo.y = afct_pkg::to_coord(req.coord_y);
        s1_box_next.lo.z = afct_pkg::to_coord(req.coord_z);
        s1_box_next.hi.x = afct_pkg::to_coord(req.box_max_x);
        s1_box_next.hi.y = afct_pkg::to_coord(req.box_max_y);
        s1_box_next.hi.z = afct_pkg::to_coord(req.box_max_z);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            s1_box_reg <= s1_box_next;
    end

    // frustum corners against box faces, resolved within stage 1
    afct_face_test u_face_test (
        .corners (corner_reg),
        .box     (s1_box_reg),
        .beyond  (face_beyond)
    );

    // per-plane products registered into stage 2
    for (genvar p = 0; p < afct_pkg::NUM_PLANES; p++)
    begin : g_plane
        afct_plane_eval u_plane_eval (
            .clk     (clk),
            .en      (pipe_en),
            .plane   (plane_reg[p]),
            .box     (s1_box_reg),
            .outside (plane_outside[p])
        );
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            s2_face_reg <= face_beyond;
    end

    // plane rejection wins over the face test
    always_comb
    begin
        if (|plane_outside)
            rsp_next.cull_cause = afct_pkg::CAUSE_PLANE;
        else if (s2_face_reg)
            rsp_next.cull_cause = afct_pkg::CAUSE_FACE;
        else
            rsp_next.cull_cause = afct_pkg::CAUSE_NONE;
        rsp_next.visible = (rsp_next.cull_cause == afct_pkg::CAUSE_NONE);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            rsp_reg <= rsp_next;
    end

    // valid bits of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            rsp_valid_reg <= s2_valid_reg;
        end
    end

    // checks
    `AFCT_ASSERT_NEXT(a_load_no_entry,
        req_accept && (req.req_type != afct_pkg::REQ_TEST), !s1_valid_reg,
        "load request created a pipeline entry")
    `AFCT_ASSERT_NEXT(a_s1_advances, s1_valid_reg && pipe_en, s2_valid_reg,
        "stage 1 entry lost on advance")
    `AFCT_ASSERT_NEXT(a_s2_held, s2_valid_reg && !pipe_en, s2_valid_reg,
        "stage 2 entry dropped while stalled")
    `AFCT_ASSERT_NOW(a_visible_cause, rsp_valid_reg,
        rsp_reg.visible == (rsp_reg.cull_cause == afct_pkg::CAUSE_NONE),
        "visible flag disagrees with cull cause")

endmodule

// ===== src/afct_plane_eval.sv =====
// ----------------------------------------------------------------------------
// afct_plane_eval
// one plane: registered products of the farthest box corner, then sign of sum
// ----------------------------------------------------------------------------
module afct_plane_eval (
    input  logic              clk,
    input  logic              en,
    input  afct_pkg::plane_t  plane,
    input  afct_pkg::box_t    box,
    output logic              outside
);

    afct_pkg::coord_t pick_x;
    afct_pkg::coord_t pick_y;
    afct_pkg::coord_t pick_z;

    logic signed [afct_pkg::PROD_BITS-1:0] prod_x_next;
    logic signed [afct_pkg::PROD_BITS-1:0] prod_y_next;
    logic signed [afct_pkg::PROD_BITS-1:0] prod_z_next;

    logic signed [afct_pkg::PROD_BITS-1:0] prod_x_reg;
    logic signed [afct_pkg::PROD_BITS-1:0] prod_y_reg;
    logic signed [afct_pkg::PROD_BITS-1:0] prod_z_reg;
    afct_pkg::coord_t                      d_reg;

    logic signed [afct_pkg::SUM_BITS-1:0]  sum;

    // the corner with the largest plane distance decides the whole box
    always_comb
    begin
        pick_x = afct_pkg::pick_extreme(plane.n.x, box.lo.x, box.hi.x);
        pick_y = afct_pkg::pick_extreme(plane.n.y, box.lo.y, box.hi.y);
        pick_z = afct_pkg::pick_extreme(plane.n.z, box.lo.z, box.hi.z);
        prod_x_next = $signed(plane.n.x) * $signed(pick_x);
        prod_y_next = $signed(plane.n.y) * $signed(pick_y);
        prod_z_next = $signed(plane.n.z) * $signed(pick_z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            d_reg      <= plane.d;
        end
    end

    // exact Q32.32 sum, d scaled up to match
    always_comb
    begin
        sum = afct_pkg::SUM_BITS'(prod_x_reg)
            + afct_pkg::SUM_BITS'(prod_y_reg)
            + afct_pkg::SUM_BITS'(prod_z_reg)
            + (afct_pkg::SUM_BITS'($signed(d_reg)) <<< afct_pkg::D_SHIFT);
        outside = sum[afct_pkg::SUM_BITS-1];
    end

endmodule

// ===== src/afct_face_test.sv =====
// ----------------------------------------------------------------------------
// afct_face_test
// flags a box when all frustum corners lie strictly beyond one of its faces
// ----------------------------------------------------------------------------
module afct_face_test (
    input  afct_pkg::vec3_t corners [afct_pkg::NUM_CORNERS],
    input  afct_pkg::box_t  box,
    output logic            beyond
);

    logic [afct_pkg::NUM_CORNERS-1:0] above_x, below_x;
    logic [afct_pkg::NUM_CORNERS-1:0] above_y, below_y;
    logic [afct_pkg::NUM_CORNERS-1:0] above_z, below_z;

    always_comb
    begin
        for (int c = 0; c < afct_pkg::NUM_CORNERS; c++)
        begin
            above_x[c] = $signed(corners[c].x) > $signed(box.hi.x);
            below_x[c] = $signed(corners[c].x) < $signed(box.lo.x);
            above_y[c] = $signed(corners[c].y) > $signed(box.hi.y);
            below_y[c] = $signed(corners[c].y) < $signed(box.lo.y);
            above_z[c] = $signed(corners[c].z) > $signed(box.hi.z);
            below_z[c] = $signed(corners[c].z) < $signed(box.lo.z);
        end
        beyond = (&above_x) | (&below_x) | (&above_y) | (&below_y)
               | (&above_z) | (&below_z);
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the box versus view frustum culling unit: a queue
// fed driver, a monitor that mirrors the plane and corner stores and predicts
// visible and cull_cause for every box test, field by field against the dut
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ONE_Q16        = 65536;
    localparam int C_MAX          = 32'sh7fff_ffff;
    localparam int C_MIN          = 32'sh8000_0000;
    localparam int WATCHDOG_LIMIT = 2000;
    // pipeline is three deep, give it a few extra
    localparam int DRAIN_CYCLES   = 10;
    // request type the unit does not decode
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    afct_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    afct_pkg::rsp_t rsp;

    aabb_frustum_cull_test_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // mirror of the unit's stores, updated in acceptance order
    afct_pkg::coord_t plane_coef [afct_pkg::NUM_PLANES][4];
    afct_pkg::coord_t frustum_pt [afct_pkg::NUM_CORNERS][3];

    afct_pkg::req_t pending_reqs [$];
    afct_pkg::rsp_t expected_verdicts [$];

    int   n_queued       = 0;
    int   n_accepted     = 0;
    int   n_errors       = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles   = 0;
    logic req_taken      = 1'b0;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic logic signed [65:0] widen(afct_pkg::coord_t v);
        return v;
    endfunction

    // exact sign of a*x + b*y + c*z + d*2^16, no rounding and no saturation
    function automatic logic below_plane(int p, afct_pkg::coord_t x, afct_pkg::coord_t y,
                                         afct_pkg::coord_t z);
        logic signed [65:0] sum;
        sum = widen(plane_coef[p][0]) * widen(x)
            + widen(plane_coef[p][1]) * widen(y)
            + widen(plane_coef[p][2]) * widen(z)
            + (widen(plane_coef[p][3]) <<< afct_pkg::D_SHIFT);
        return sum < 0;
    endfunction

    function automatic afct_pkg::rsp_t cull_box(afct_pkg::req_t r);
        afct_pkg::coord_t lo [3];
        afct_pkg::coord_t hi [3];
        afct_pkg::coord_t v;
        logic [1:0]       cause;
        int               n_out;
        int               n_above;
        int               n_below;
        afct_pkg::rsp_t   verdict;
        lo[0] = r.coord_x;
        lo[1] = r.coord_y;
        lo[2] = r.coord_z;
        hi[0] = r.box_max_x;
        hi[1] = r.box_max_y;
        hi[2] = r.box_max_z;
        cause = afct_pkg::CAUSE_NONE;
        // box corners: every lo/hi pick per axis, even when lo is above hi
        for (int p = 0; p < afct_pkg::NUM_PLANES && cause == afct_pkg::CAUSE_NONE; p++)
        begin
            n_out = 0;
            for (int c = 0; c < 8; c++)
            begin
                if (below_plane(p, (c & 1) ? hi[0] : lo[0], (c & 2) ? hi[1] : lo[1],
                                (c & 4) ? hi[2] : lo[2]))
                    n_out++;
            end
            if (n_out == 8)
                cause = afct_pkg::CAUSE_PLANE;
        end
        // whole frustum strictly past one box face
        for (int ax = 0; ax < 3 && cause == afct_pkg::CAUSE_NONE; ax++)
        begin
            n_above = 0;
            n_below = 0;
            for (int c = 0; c < afct_pkg::NUM_CORNERS; c++)
            begin
                v = frustum_pt[c][ax];
                if (v > hi[ax])
                    n_above++;
                if (v < lo[ax])
                    n_below++;
            end
            if (n_above == afct_pkg::NUM_CORNERS || n_below == afct_pkg::NUM_CORNERS)
                cause = afct_pkg::CAUSE_FACE;
        end
        verdict.visible    = (cause == afct_pkg::CAUSE_NONE);
        verdict.cull_cause = cause;
        return verdict;
    endfunction

    // ------------------------------------------------------------------------
    // request builders
    // ------------------------------------------------------------------------

    function automatic afct_pkg::req_t make_plane(int slot, int a, int b, int c, int d);
        afct_pkg::req_t r;
        r = '0;
        r.req_type     = afct_pkg::REQ_PLANE;
        r.slot         = 3'(slot);
        r.coord_x      = a;
        r.coord_y      = b;
        r.coord_z      = c;
        r.plane_offset = d;
        return r;
    endfunction

    function automatic afct_pkg::req_t make_corner(int slot, int x, int y, int z);
        afct_pkg::req_t r;
        r = '0;
        r.req_type = afct_pkg::REQ_CORNER;
        r.slot     = 3'(slot);
        r.coord_x  = x;
        r.coord_y  = y;
        r.coord_z  = z;
        return r;
    endfunction

    function automatic afct_pkg::req_t make_box(int x0, int y0, int z0, int x1, int y1,
                                                int z1);
        afct_pkg::req_t r;
        r = '0;
        r.req_type  = afct_pkg::REQ_TEST;
        r.coord_x   = x0;
        r.coord_y   = y0;
        r.coord_z   = z0;
        r.box_max_x = x1;
        r.box_max_y = y1;
        r.box_max_z = z1;
        return r;
    endfunction

    // uniform in [-lim, lim]
    function automatic int rand_span(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    task automatic queue_req(afct_pkg::req_t r);
        pending_reqs = {pending_reqs, r};
        n_queued++;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    task automatic add_directed();
        afct_pkg::req_t r;
        // empty stores: zero planes never cull, zero corners only cull
        // boxes that exclude the origin
        queue_req(make_box(0, 0, 0, 0, 0, 0));
        queue_req(make_box(ONE_Q16, ONE_Q16, ONE_Q16, 2 * ONE_Q16, 2 * ONE_Q16, 2 * ONE_Q16));
        queue_req(make_box(-2 * ONE_Q16, -2 * ONE_Q16, -2 * ONE_Q16, -ONE_Q16, -ONE_Q16,
                           -ONE_Q16));
        // undecoded type and plane slots past the last plane are dropped
        r = '1;
        r.req_type = REQ_UNUSED;
        queue_req(r);
        queue_req(make_plane(afct_pkg::NUM_PLANES, C_MIN, C_MIN, C_MIN, C_MIN));
        queue_req(make_plane(afct_pkg::NUM_PLANES + 1, C_MAX, C_MAX, C_MAX, C_MAX));
        // half space x >= 0, then a box behind it and one across it
        queue_req(make_plane(0, ONE_Q16, 0, 0, 0));
        queue_req(make_box(-2 * ONE_Q16, -ONE_Q16, -ONE_Q16, -ONE_Q16, ONE_Q16, ONE_Q16));
        queue_req(make_box(-ONE_Q16, -ONE_Q16, -ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16));
        // frustum hull in front of the plane
        for (int c = 0; c < afct_pkg::NUM_CORNERS; c++)
            queue_req(make_corner(c, (c & 1) ? 4 * ONE_Q16 : ONE_Q16,
                                  (c & 2) ? 4 * ONE_Q16 : -4 * ONE_Q16,
                                  (c & 4) ? 8 * ONE_Q16 : ONE_Q16));
        // min above max, then a box past every corner in x
        queue_req(make_box(ONE_Q16, ONE_Q16, ONE_Q16, -ONE_Q16, -ONE_Q16, -ONE_Q16));
        queue_req(make_box(10 * ONE_Q16, 0, 0, 12 * ONE_Q16, ONE_Q16, ONE_Q16));
        // extreme coefficients and coordinates, full-width sums
        queue_req(make_plane(1, C_MIN, C_MIN, C_MIN, C_MIN));
        queue_req(make_plane(2, C_MAX, C_MAX, C_MAX, C_MAX));
        queue_req(make_corner(afct_pkg::NUM_CORNERS - 1, C_MAX, C_MIN, C_MAX));
        queue_req(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        queue_req(make_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
        queue_req(make_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    endtask

    // frames: reload every plane and corner, then a burst of boxes, with
    // some raw noise mixed in that may also clobber the stores
    task automatic add_random(int n_items);
        int             n_done;
        int             open_pct;
        int             ctr;
        int             half;
        int             lo [3];
        int             hi [3];
        int             tmp;
        afct_pkg::req_t r;
        n_done = 0;
        while (n_done < n_items)
        begin
            // sometimes every plane is open so face culls get through
            open_pct = ($urandom_range(3) == 0) ? 100 : 30;
            for (int p = 0; p < afct_pkg::NUM_PLANES; p++)
            begin
                if ($urandom_range(99) < open_pct)
                    queue_req(make_plane(p, 0, 0, 0, int'($urandom_range(ONE_Q16, 8 * ONE_Q16))));
                else
                    queue_req(make_plane(p, rand_span(2 * ONE_Q16), rand_span(2 * ONE_Q16),
                                         rand_span(2 * ONE_Q16),
                                         int'($urandom_range(ONE_Q16, 8 * ONE_Q16))));
            end
            for (int c = 0; c < afct_pkg::NUM_CORNERS; c++)
                queue_req(make_corner(c, rand_span(6 * ONE_Q16), rand_span(6 * ONE_Q16),
                                      rand_span(6 * ONE_Q16)));
            n_done += afct_pkg::NUM_PLANES + afct_pkg::NUM_CORNERS;
            repeat ($urandom_range(4, 24))
            begin
                if ($urandom_range(9) == 0)
                begin
                    r.req_type     = 2'($urandom_range(3));
                    r.slot         = 3'($urandom_range(7));
                    r.coord_x      = $urandom;
                    r.coord_y      = $urandom;
                    r.coord_z      = $urandom;
                    r.plane_offset = $urandom;
                    r.box_max_x    = $urandom;
                    r.box_max_y    = $urandom;
                    r.box_max_z    = $urandom;
                    queue_req(r);
                    if (!(r.req_type == REQ_UNUSED ||
                          (r.req_type == afct_pkg::REQ_PLANE &&
                           r.slot >= afct_pkg::NUM_PLANES)))
                        n_done++;
                end
                else
                begin
                    for (int ax = 0; ax < 3; ax++)
                    begin
                        ctr     = rand_span(12 * ONE_Q16);
                        half    = $urandom_range(0, 4 * ONE_Q16);
                        lo[ax]  = ctr - half;
                        hi[ax]  = ctr + half;
                        // occasional inverted axis
                        if ($urandom_range(9) == 0)
                        begin
                            tmp    = lo[ax];
                            lo[ax] = hi[ax];
                            hi[ax] = tmp;
                        end
                    end
                    queue_req(make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]));
                    n_done++;
                end
            end
        end
    endtask

    // sender holds off until every request is in and every verdict is back
    task automatic wait_drained();
        while (n_accepted != n_queued || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // driver: inputs move on the falling edge only
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // a request stays up, payload fixed, until it has been taken
            if (!req_valid || req_taken)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor, predictor update, checker and watchdog on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        req_taken <= req_valid && req_ready;
        if (req_valid && req_ready)
        begin
            n_accepted++;
            // loads land at the accepting edge, so a test right behind sees them
            case (req.req_type)
                afct_pkg::REQ_PLANE:
                begin
                    if (req.slot < afct_pkg::NUM_PLANES)
                    begin
                        plane_coef[req.slot][0] = req.coord_x;
                        plane_coef[req.slot][1] = req.coord_y;
                        plane_coef[req.slot][2] = req.coord_z;
                        plane_coef[req.slot][3] = req.plane_offset;
                    end
                end
                afct_pkg::REQ_CORNER:
                begin
                    frustum_pt[req.slot][0] = req.coord_x;
                    frustum_pt[req.slot][1] = req.coord_y;
                    frustum_pt[req.slot][2] = req.coord_z;
                end
                afct_pkg::REQ_TEST:
                    expected_verdicts = {expected_verdicts, cull_box(req)};
                default:
                    ;
            endcase
        end
        if (rsp_valid && rsp_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: response with no test pending, visible=%0b cause=%0d",
                         $time, rsp.visible, rsp.cull_cause);
                n_errors++;
            end
            else
            begin
                if (rsp.visible !== expected_verdicts[0].visible)
                begin
                    $display("%0t: visible mismatch, expected %0b, actual %0b",
                             $time, expected_verdicts[0].visible, rsp.visible);
                    n_errors++;
                end
                if (rsp.cull_cause !== expected_verdicts[0].cull_cause)
                begin
                    $display("%0t: cull_cause mismatch, expected %0d, actual %0d",
                             $time, expected_verdicts[0].cull_cause, rsp.cull_cause);
                    n_errors++;
                end
                void'(expected_verdicts.pop_front());
            end
        end
        // watchdog: consecutive cycles with no transfer on either side
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence: reset, then three phases with different idle patterns
    // ------------------------------------------------------------------------
    initial
    begin
        plane_coef = '{default: '0};
        frustum_pt = '{default: '0};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender mostly busy, receiver stalling hard
        send_idle_pct  = 15;
        recv_stall_pct = 68;
        add_directed();
        add_random(150);
        wait_drained();

        // sender sparse, receiver mostly ready
        send_idle_pct  = 68;
        recv_stall_pct = 15;
        add_random(150);
        wait_drained();

        // full rate both ways
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_random(150);
        wait_drained();

        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/afct_pkg.sv
src/afct_plane_eval.sv
src/afct_face_test.sv
src/aabb_frustum_cull_test_unit.sv
tb/sv/tb_top.sv
